// ===== hw/rtl/spk_pkg.sv =====
package spk_pkg;

    // fixed widths of the ports
    localparam int DATA_BITS = 32;
    localparam int KEY_REGS  = 4;
    localparam int KEY_IDX_BITS = $clog2(KEY_REGS);

    // rotation amounts of the round
    localparam int ALPHA = 8;
    localparam int BETA  = 3;

    // defaults for the top level parameters
    localparam int WORD_BITS_DEF = 32;
    localparam int KEY_WORDS_DEF = 4;
    localparam int ROUNDS_DEF    = 27;

    // action codes
    localparam logic ACT_ENC = 1'b0;
    localparam logic ACT_DEC = 1'b1;

    typedef struct packed {
        logic valid;
        logic action;
    } stage_ctl_t;

endpackage

// ===== hw/rtl/spk_key_sched.sv =====
module spk_key_sched #(
    parameter int WORD_BITS = spk_pkg::WORD_BITS_DEF,
    parameter int KEY_WORDS = spk_pkg::KEY_WORDS_DEF,
    parameter int ROUNDS    = spk_pkg::ROUNDS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [spk_pkg::KEY_IDX_BITS-1:0] cfg_index,
    input  logic [spk_pkg::DATA_BITS-1:0]   cfg_data,
    output logic                            keys_ready,
    output logic [WORD_BITS-1:0]            round_key [ROUNDS]
);
    import spk_pkg::*;

    localparam int STEP_BITS = $clog2(ROUNDS);
    localparam int RING      = KEY_WORDS - 1;

    typedef enum logic [1:0] {KS_LOAD, KS_RUN, KS_DONE} ks_state_t;

    ks_state_t              st_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic [DATA_BITS-1:0]   key_reg  [KEY_REGS];
    logic [WORD_BITS-1:0]   ring_reg [RING];
    logic [WORD_BITS-1:0]   cur_reg;
    logic [WORD_BITS-1:0]   rk_reg   [ROUNDS];

    logic [WORD_BITS-1:0]   rc;
    logic [WORD_BITS-1:0]   ring_rot;
    logic [WORD_BITS-1:0]   ring_next;
    logic [WORD_BITS-1:0]   cur_next;

    // one speck round on (ring head, current key) with the step number as key
    always_comb begin
        rc        = WORD_BITS'(step_reg);
        ring_rot  = {ring_reg[0][ALPHA-1:0], ring_reg[0][WORD_BITS-1:ALPHA]};
        ring_next = (ring_rot + cur_reg) ^ rc;
        cur_next  = {cur_reg[WORD_BITS-1-BETA:0], cur_reg[WORD_BITS-1:WORD_BITS-BETA]}
                    ^ ring_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= KS_LOAD;
            step_reg <= '0;
            for (int i = 0; i < KEY_REGS; i++) begin
                key_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            key_reg[cfg_index] <= cfg_data;
            st_reg             <= KS_LOAD;
        end else begin
            case (st_reg)
                KS_LOAD: begin
                    cur_reg   <= WORD_BITS'(key_reg[0]);
                    rk_reg[0] <= WORD_BITS'(key_reg[0]);
                    for (int k = 0; k < RING; k++) begin
                        ring_reg[k] <= WORD_BITS'(key_reg[k+1]);
                    end
                    step_reg <= '0;
                    st_reg   <= KS_RUN;
                end
                KS_RUN: begin
                    cur_reg <= cur_next;
                    for (int k = 0; k < RING - 1; k++) begin
                        ring_reg[k] <= ring_reg[k+1];
                    end
                    ring_reg[RING-1] <= ring_next;
                    rk_reg[STEP_BITS'(step_reg + 1'b1)] <= cur_next;
                    step_reg <= STEP_BITS'(step_reg + 1'b1);
                    if (step_reg == STEP_BITS'(ROUNDS - 2)) begin
                        st_reg <= KS_DONE;
                    end
                end
                KS_DONE: begin
                    st_reg <= KS_DONE;
                end
                default: begin
                    st_reg <= KS_LOAD;
                end
            endcase
        end
    end

    assign keys_ready = (st_reg == KS_DONE);
    assign round_key  = rk_reg;

endmodule

// ===== hw/rtl/spk_round.sv =====
module spk_round #(
    parameter int WORD_BITS = spk_pkg::WORD_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  spk_pkg::stage_ctl_t    ctl_in,
    input  logic [WORD_BITS-1:0]   x_in,
    input  logic [WORD_BITS-1:0]   y_in,
    input  logic [WORD_BITS-1:0]   key_enc,
    input  logic [WORD_BITS-1:0]   key_dec,
    output spk_pkg::stage_ctl_t    ctl_out,
    output logic [WORD_BITS-1:0]   x_out,
    output logic [WORD_BITS-1:0]   y_out
);
    import spk_pkg::*;

    stage_ctl_t             ctl_reg;
    logic [WORD_BITS-1:0]   x_reg;
    logic [WORD_BITS-1:0]   y_reg;
    logic [WORD_BITS-1:0]   x_next;
    logic [WORD_BITS-1:0]   y_next;

    logic [WORD_BITS-1:0]   fx_rot;
    logic [WORD_BITS-1:0]   fy_rot;
    logic [WORD_BITS-1:0]   fx;
    logic [WORD_BITS-1:0]   iy_xor;
    logic [WORD_BITS-1:0]   iy;
    logic [WORD_BITS-1:0]   ix_diff;

    always_comb begin
        // forward round
        fx_rot  = {x_in[ALPHA-1:0], x_in[WORD_BITS-1:ALPHA]};
        fx      = (fx_rot + y_in) ^ key_enc;
        fy_rot  = {y_in[WORD_BITS-1-BETA:0], y_in[WORD_BITS-1:WORD_BITS-BETA]};
        // inverse round
        iy_xor  = y_in ^ x_in;
        iy      = {iy_xor[BETA-1:0], iy_xor[WORD_BITS-1:BETA]};
        ix_diff = (x_in ^ key_dec) - iy;
        if (ctl_in.action == ACT_DEC) begin
            x_next = {ix_diff[WORD_BITS-1-ALPHA:0], ix_diff[WORD_BITS-1:WORD_BITS-ALPHA]};
            y_next = iy;
        end else begin
            x_next = fx;
            y_next = fy_rot ^ fx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && ctl_in.valid) begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;

endmodule

// ===== hw/rtl/speck_block_cipher_core.sv =====
// Speck block cipher core, Speck64/128 by default. Key words are written over the
// cfg port; every word on s_ carries a block and an action (encrypt or decrypt)
// and yields one word on m_ in the same order. The rounds are fully unrolled, one
// round per pipeline stage, so the core takes one block per cycle while m_ready
// allows it; a stalled output freezes the whole pipeline. After reset and after
// every key write the round keys are rebuilt by a single shared round unit, one
// key a cycle, and s_ready stays low until the last round key is built; keys may
// only be written while no block is in flight.
module speck_block_cipher_core #(
    parameter int WORD_BITS = spk_pkg::WORD_BITS_DEF,
    parameter int KEY_WORDS = spk_pkg::KEY_WORDS_DEF,
    parameter int ROUNDS    = spk_pkg::ROUNDS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_action,
    input  logic [spk_pkg::DATA_BITS-1:0]   s_block_x,
    input  logic [spk_pkg::DATA_BITS-1:0]   s_block_y,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [spk_pkg::DATA_BITS-1:0]   m_out_x,
    output logic [spk_pkg::DATA_BITS-1:0]   m_out_y,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [spk_pkg::KEY_IDX_BITS-1:0] cfg_index,
    input  logic [spk_pkg::DATA_BITS-1:0]   cfg_data
);
    import spk_pkg::*;

    logic                   keys_ready;
    logic [WORD_BITS-1:0]   round_key [ROUNDS];
    logic                   advance;

    stage_ctl_t             ctl   [ROUNDS+1];
    logic [WORD_BITS-1:0]   x_st  [ROUNDS+1];
    logic [WORD_BITS-1:0]   y_st  [ROUNDS+1];

    assign cfg_ready = 1'b1;

    spk_key_sched #(
        .WORD_BITS (WORD_BITS),
        .KEY_WORDS (KEY_WORDS),
        .ROUNDS    (ROUNDS)
    ) u_key_sched (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .keys_ready (keys_ready),
        .round_key  (round_key)
    );

    // last stage doubles as the output register
    assign advance = !ctl[ROUNDS].valid || m_ready;
    assign s_ready = keys_ready && advance;

    assign ctl[0].valid  = s_valid && s_ready;
    assign ctl[0].action = s_action;
    assign x_st[0]       = WORD_BITS'(s_block_x);
    assign y_st[0]       = WORD_BITS'(s_block_y);

    for (genvar i = 0; i < ROUNDS; i++) begin : g_round
        spk_round #(
            .WORD_BITS (WORD_BITS)
        ) u_round (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (advance),
            .ctl_in  (ctl[i]),
            .x_in    (x_st[i]),
            .y_in    (y_st[i]),
            .key_enc (round_key[i]),
            .key_dec (round_key[ROUNDS-1-i]),
            .ctl_out (ctl[i+1]),
            .x_out   (x_st[i+1]),
            .y_out   (y_st[i+1])
        );
    end

    assign m_valid = ctl[ROUNDS].valid;
    assign m_out_x = x_st[ROUNDS][DATA_BITS-1:0];
    assign m_out_y = y_st[ROUNDS][DATA_BITS-1:0];

endmodule
